>>> hdl/lkv_pkg.sv
// lkv_pkg: shared types, constants and codes for the lru key-value cache
`default_nettype none

package lkv_pkg;

  // store geometry
  localparam int MaxEntries = 8;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int RankW      = IdxW;
  localparam int CountW     = $clog2(MaxEntries + 1);
  localparam int CapW       = 4;
  localparam int DataW      = 32;

  // result word for a miss or a put
  localparam logic [DataW-1:0] MissValue = '1;

  // operation codes
  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  // request item
  typedef struct packed {
    op_t                     operation;
    logic signed [DataW-1:0] key;
    logic signed [DataW-1:0] value;
  } req_t;

  // response item
  typedef struct packed {
    logic                    hit;
    logic signed [DataW-1:0] read_value;
    logic                    evicted;
    logic signed [DataW-1:0] evicted_key;
  } rsp_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_WRITE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_req;
    logic match;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic rsp_free;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> hdl/lkv_datapath.sv
// lkv_datapath: entry store, tag compare, lru ranks and response register
`default_nettype none

module lkv_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lkv_pkg::ctrl_cmd_t cmd,
  output lkv_pkg::dp_sts_t        sts,
  input  wire lkv_pkg::req_t      req,
  input  wire logic               cfg_valid,
  input  wire logic [lkv_pkg::CapW-1:0] cfg_data,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output lkv_pkg::rsp_t           rsp
);

  localparam int N = lkv_pkg::MaxEntries;

  // entry store
  logic [lkv_pkg::DataW-1:0]  keys   [N];
  logic [lkv_pkg::DataW-1:0]  values [N];
  logic [N-1:0]               valid;
  logic [lkv_pkg::RankW-1:0]  rank   [N];
  logic [lkv_pkg::CountW-1:0] entry_count;
  logic [lkv_pkg::CapW-1:0]   capacity;

  // latched request
  lkv_pkg::req_t req_q;

  // match stage results
  logic                      hit_q;
  logic                      evict_q;
  logic                      age_all_q;
  logic [lkv_pkg::IdxW-1:0]  slot_q;
  logic [lkv_pkg::RankW-1:0] old_rank_q;

  // combinational lookup
  logic [lkv_pkg::CapW-1:0]   eff_cap;
  logic [N-1:0]               match_vec;
  logic [N-1:0]               victim_vec;
  logic [N-1:0]               free_vec;
  logic                       match_any;
  logic                       victim_any;
  logic                       free_any;
  logic [lkv_pkg::IdxW-1:0]   match_idx;
  logic [lkv_pkg::IdxW-1:0]   victim_idx;
  logic [lkv_pkg::IdxW-1:0]   free_idx;
  logic                       full;
  logic [lkv_pkg::CountW-1:0] oldest_rank;

  // capacity register, always ready
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkv_pkg::CapW'(N);
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req;
    end
  end

  // clamp capacity to 1..MaxEntries
  always_comb begin
    if (capacity == '0) begin
      eff_cap = lkv_pkg::CapW'(1);
    end else if (capacity > lkv_pkg::CapW'(N)) begin
      eff_cap = lkv_pkg::CapW'(N);
    end else begin
      eff_cap = capacity;
    end
  end

  assign full        = lkv_pkg::CapW'(entry_count) >= eff_cap;
  assign oldest_rank = entry_count - lkv_pkg::CountW'(1);

  // per-entry compares: key match, oldest valid entry, free slot
  always_comb begin
    for (int i = 0; i < N; i++) begin
      match_vec[i]  = valid[i] && (keys[i] == req_q.key);
      victim_vec[i] = valid[i] && (lkv_pkg::CountW'(rank[i]) == oldest_rank);
      free_vec[i]   = !valid[i];
    end
  end

  // lowest-index pick for each vector
  always_comb begin
    match_any  = 1'b0;
    victim_any = 1'b0;
    free_any   = 1'b0;
    match_idx  = '0;
    victim_idx = '0;
    free_idx   = '0;
    for (int i = 0; i < N; i++) begin
      if (match_vec[i] && !match_any) begin
        match_any = 1'b1;
        match_idx = lkv_pkg::IdxW'(i);
      end
      if (victim_vec[i] && !victim_any) begin
        victim_any = 1'b1;
        victim_idx = lkv_pkg::IdxW'(i);
      end
      if (free_vec[i] && !free_any) begin
        free_any = 1'b1;
        free_idx = lkv_pkg::IdxW'(i);
      end
    end
  end

  // register the lookup decision
  always_ff @(posedge clk) begin
    if (cmd.match) begin
      hit_q <= match_any;
      if (match_any) begin
        slot_q     <= match_idx;
        old_rank_q <= rank[match_idx];
        evict_q    <= 1'b0;
        age_all_q  <= 1'b0;
      end else if (full && victim_any) begin
        slot_q     <= victim_idx;
        old_rank_q <= rank[victim_idx];
        evict_q    <= (req_q.operation == lkv_pkg::OP_PUT);
        age_all_q  <= 1'b0;
      end else begin
        slot_q     <= free_idx;
        old_rank_q <= '0;
        evict_q    <= 1'b0;
        age_all_q  <= 1'b1;
      end
    end
  end

  // store update: a get miss leaves everything alone
  logic do_update;
  logic do_insert;
  logic do_write;
  assign do_update = cmd.commit && (hit_q || req_q.operation == lkv_pkg::OP_PUT);
  assign do_insert = do_update && !hit_q;
  assign do_write  = cmd.commit && (req_q.operation == lkv_pkg::OP_PUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      entry_count <= '0;
      for (int i = 0; i < N; i++) begin
        rank[i] <= '0;
      end
    end else if (do_update) begin
      for (int i = 0; i < N; i++) begin
        if (lkv_pkg::IdxW'(i) == slot_q) begin
          rank[i] <= '0;
        end else if (valid[i] && (age_all_q || rank[i] < old_rank_q)) begin
          rank[i] <= rank[i] + lkv_pkg::RankW'(1);
        end
      end
      if (do_insert) begin
        valid[slot_q] <= 1'b1;
        if (!evict_q) begin
          entry_count <= entry_count + lkv_pkg::CountW'(1);
        end
      end
    end
  end

  // key and value words, the value only on a put
  always_ff @(posedge clk) begin
    if (do_insert) begin
      keys[slot_q] <= req_q.key;
    end
    if (do_write) begin
      values[slot_q] <= req_q.value;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.hit     <= hit_q;
      rsp.evicted <= evict_q;
      if (hit_q && req_q.operation == lkv_pkg::OP_GET) begin
        rsp.read_value <= values[slot_q];
      end else begin
        rsp.read_value <= lkv_pkg::MissValue;
      end
      if (evict_q) begin
        rsp.evicted_key <= keys[slot_q];
      end else begin
        rsp.evicted_key <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  assign sts.rsp_free = !rsp_valid || !rsp_stall;

endmodule

`default_nettype wire

>>> hdl/lkv_ctrl.sv
// lkv_ctrl: request sequencing state machine
`default_nettype none

module lkv_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire lkv_pkg::dp_sts_t sts,
  output lkv_pkg::ctrl_cmd_t    cmd
);

  lkv_pkg::state_t state;
  lkv_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkv_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lkv_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = lkv_pkg::ST_MATCH;
        end
      end
      lkv_pkg::ST_MATCH: begin
        state_next = lkv_pkg::ST_WRITE;
      end
      lkv_pkg::ST_WRITE: begin
        if (sts.rsp_free) begin
          state_next = lkv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lkv_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    req_stall    = 1'b1;
    cmd.load_req = 1'b0;
    cmd.match    = 1'b0;
    cmd.commit   = 1'b0;
    unique case (state)
      lkv_pkg::ST_IDLE: begin
        req_stall    = 1'b0;
        cmd.load_req = req_valid;
      end
      lkv_pkg::ST_MATCH: begin
        cmd.match = 1'b1;
      end
      lkv_pkg::ST_WRITE: begin
        cmd.commit = sts.rsp_free;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/lru_key_value_cache.sv
// lru_key_value_cache: top level of the eight-entry lru key-value cache
`default_nettype none

// Fully associative key-value cache of eight entries with least-recently-used
// replacement. Each request item is a get or a put; each gives exactly one
// response item. An item is latched at the edge that accepts it; the eight
// parallel key compares and the choice of slot are then registered in the
// match state, and in the write state the entry and the lru ranks are updated
// and the response is loaded once the response register has room. A new item
// is taken only after the previous one is committed, and a commit waits while
// a finished response is held by rsp_stall. The response register lets a
// new item be accepted while the previous response waits. cfg_data sets the
// capacity (clamped to 1..8) and is always ready; write it only while the
// cache is idle. No clearing pass: valid bits reset at once.
module lru_key_value_cache (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     req_valid,
  output logic                          req_stall,
  input  wire lkv_pkg::req_t            req,
  output logic                          rsp_valid,
  input  wire logic                     rsp_stall,
  output lkv_pkg::rsp_t                 rsp,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [lkv_pkg::CapW-1:0] cfg_data
);

  lkv_pkg::ctrl_cmd_t cmd;
  lkv_pkg::dp_sts_t   sts;

  assign cfg_ready = 1'b1;

  // sequencer
  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // store and compare logic
  lkv_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // an eviction only happens on a put of a new key
  a_evict_is_put_miss: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.evicted) |-> (!rsp.hit && rsp.read_value == lkv_pkg::MissValue))
    else $error("eviction reported on a hit or with a read value");

  // a miss never returns a stored value
  a_miss_reads_ones: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.hit) |-> (rsp.read_value == lkv_pkg::MissValue))
    else $error("miss returned a value other than all ones");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while previous item still in work");

  // a commit only when the response register can take it
  a_commit_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> sts.rsp_free)
    else $error("response overwritten while stalled");

endmodule

`default_nettype wire

>>> verif/lru_key_value_cache_tb.sv
// lru_key_value_cache_tb: self-checking testbench for the lru key-value cache
module lru_key_value_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lkv_pkg::*;

  localparam int SettleCycles = 12;
  localparam int PoolMax      = 16;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;
  logic cfg_valid;
  logic cfg_ready;
  logic [CapW-1:0] cfg_data;

  // shadow copy of the cache contents and recency
  logic [DataW-1:0] shadow_key [MaxEntries];
  logic [DataW-1:0] shadow_value [MaxEntries];
  bit shadow_valid [MaxEntries];
  int unsigned shadow_rank [MaxEntries];
  int unsigned shadow_count;
  logic [CapW-1:0] shadow_capacity;

  // lookups accepted whose responses have not come back yet
  rsp_t results_due[$];
  int fail_count;

  // traffic shaping
  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;
  int hold_cnt;

  // keys reused so that hits and evictions are frequent
  logic [DataW-1:0] key_pool [PoolMax];
  int pool_size;

  lru_key_value_cache u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // 2 ns clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // mark slot s most recent, entries younger than its old rank age by one
  function automatic void make_recent(int s, int unsigned old_rank);
    for (int i = 0; i < MaxEntries; i++) begin
      if (shadow_valid[i] && i != s && shadow_rank[i] < old_rank) begin
        shadow_rank[i]++;
      end
    end
    shadow_rank[s] = 0;
  endfunction

  // apply one get or put to the shadow cache and return its response
  function automatic rsp_t lru_access(req_t r);
    rsp_t res;
    int found;
    int slot;
    int unsigned best;
    int unsigned old_rank;
    int unsigned eff_cap;
    res.hit         = 1'b0;
    res.read_value  = MissValue;
    res.evicted     = 1'b0;
    res.evicted_key = '0;
    found           = -1;
    for (int i = 0; i < MaxEntries; i++) begin
      if (found < 0 && shadow_valid[i] && shadow_key[i] == r.key) found = i;
    end
    if (found >= 0) begin
      res.hit = 1'b1;
      if (r.operation == OP_GET) begin
        res.read_value = shadow_value[found];
      end else begin
        shadow_value[found] = r.value;
      end
      make_recent(found, shadow_rank[found]);
    end else if (r.operation == OP_PUT) begin
      // zero capacity acts as one, oversize saturates
      eff_cap = 32'(shadow_capacity);
      if (eff_cap == 0) eff_cap = 1;
      if (eff_cap > MaxEntries) eff_cap = MaxEntries;
      slot     = -1;
      best     = 0;
      old_rank = 32'hFFFF_FFFF;
      if (shadow_count >= eff_cap) begin
        // evict the oldest valid entry, lowest slot on a tie
        for (int i = 0; i < MaxEntries; i++) begin
          if (shadow_valid[i] && (slot < 0 || shadow_rank[i] > best)) begin
            slot = i;
            best = shadow_rank[i];
          end
        end
        if (slot < 0) slot = 0;
        if (shadow_valid[slot]) begin
          res.evicted     = 1'b1;
          res.evicted_key = shadow_key[slot];
          old_rank        = shadow_rank[slot];
        end else begin
          shadow_count++;
        end
      end else begin
        // lowest free slot
        for (int i = 0; i < MaxEntries; i++) begin
          if (slot < 0 && !shadow_valid[i]) slot = i;
        end
        if (slot < 0) slot = 0;
        if (!shadow_valid[slot]) shadow_count++;
      end
      shadow_valid[slot] = 1'b1;
      shadow_key[slot]   = r.key;
      shadow_value[slot] = r.value;
      make_recent(slot, old_rank);
    end
    return res;
  endfunction

  // track accepted items, config writes and responses
  always @(posedge clk) begin : track
    rsp_t due;
    if (!rst) begin
      if (cfg_valid && cfg_ready) shadow_capacity = cfg_data;
      if (req_valid && !req_stall) results_due.push_back(lru_access(req));
      if (rsp_valid && !rsp_stall) begin
        if (results_due.size() == 0) begin
          $error("response item with no lookup outstanding");
          fail_count++;
        end else begin
          due = results_due.pop_front();
          if (rsp.hit !== due.hit) begin
            $error("hit: expected %0d, got %0d", due.hit, rsp.hit);
            fail_count++;
          end
          if (rsp.read_value !== due.read_value) begin
            $error("read_value: expected %0d, got %0d", due.read_value, rsp.read_value);
            fail_count++;
          end
          if (rsp.evicted !== due.evicted) begin
            $error("evicted: expected %0d, got %0d", due.evicted, rsp.evicted);
            fail_count++;
          end
          if (rsp.evicted_key !== due.evicted_key) begin
            $error("evicted_key: expected %0d, got %0d", due.evicted_key, rsp.evicted_key);
            fail_count++;
          end
        end
      end
    end
  end

  // response side stall, random or held off for a counted stretch
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // offer one item, with random idle cycles first, and wait until taken
  task automatic send_item(op_t op, logic [DataW-1:0] k, logic [DataW-1:0] v);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid     <= 1'b1;
    req.operation <= op;
    req.key       <= k;
    req.value     <= v;
    do @(posedge clk); while (req_stall);
  endtask

  // stop offering and wait for every outstanding response
  task automatic wait_all_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // capacity write, only once the cache is idle
  task automatic set_capacity(logic [CapW-1:0] c);
    wait_all_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // field extremes, hits, overwrites, misses and the first eviction
  task automatic test_directed_basics();
    send_item(OP_GET, 32'h0000_0000, 32'h1234_5678);
    send_item(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_GET, 32'h8000_0000, 32'h0);
    send_item(OP_PUT, 32'h7FFF_FFFF, 32'd123);
    send_item(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    for (int k = 10; k < 14; k++) send_item(OP_PUT, k, k * 3);
    send_item(OP_GET, 32'h0000_0000, 32'h0);
    send_item(OP_PUT, 32'd14, 32'd42);
    send_item(OP_GET, 32'hFFFF_FFFF, 32'h0);
    send_item(OP_GET, 32'd10, 32'h0);
  endtask

  // capacity at one, zero and above the store size, lowered below the count
  task automatic test_capacity_extremes();
    set_capacity(4'd1);
    send_item(OP_PUT, 32'd100, 32'd1);
    send_item(OP_PUT, 32'd101, 32'd2);
    send_item(OP_GET, 32'd101, 32'd0);
    set_capacity(4'd0);
    send_item(OP_PUT, 32'd200, 32'd3);
    send_item(OP_GET, 32'd101, 32'd0);
    set_capacity(4'd15);
    send_item(OP_PUT, 32'd300, 32'd4);
    send_item(OP_GET, 32'd200, 32'd0);
    set_capacity(4'd8);
  endtask

  // fresh key pool, extremes now and then
  task automatic refill_key_pool();
    pool_size = $urandom_range(3, PoolMax);
    for (int i = 0; i < PoolMax; i++) begin
      case ($urandom_range(0, 9))
        0: key_pool[i] = 32'h8000_0000;
        1: key_pool[i] = 32'h7FFF_FFFF;
        default: key_pool[i] = $urandom;
      endcase
    end
  endtask

  // random gets and puts mostly over a small key pool
  task automatic test_random_traffic(int n);
    logic [DataW-1:0] k;
    op_t op;
    refill_key_pool();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, pool_size - 1)];
      else k = $urandom;
      op = ($urandom_range(0, 99) < 55) ? OP_PUT : OP_GET;
      send_item(op, k, $urandom);
    end
  endtask

  // response side held off long enough to fill the cache and stall requests
  task automatic test_backpressure();
    int saved_send;
    int saved_recv;
    saved_send    = send_idle_pct;
    saved_recv    = recv_idle_pct;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_all_results();
    hold_req = 300;
    test_random_traffic(24);
    wait_all_results();
    test_random_traffic(16);
    send_idle_pct = saved_send;
    recv_idle_pct = saved_recv;
  endtask

  // one idling profile, capacity changed between chunks
  task automatic test_idle_profile(int send_pct, int recv_pct, int chunks);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int c = 0; c < chunks; c++) begin
      set_capacity(CapW'($urandom_range(0, 15)));
      test_random_traffic(150);
    end
  endtask

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    rsp_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    hold_req  = 0;
    hold_cnt  = 0;
    fail_count    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    shadow_count    = 0;
    shadow_capacity = 4'd8;
    for (int i = 0; i < MaxEntries; i++) begin
      shadow_key[i]   = '0;
      shadow_value[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_rank[i]  = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_basics();
    test_capacity_extremes();
    test_idle_profile(37, 65, 3);
    test_backpressure();
    test_idle_profile(65, 37, 3);
    test_idle_profile(0, 0, 2);
    set_capacity(4'd8);
    test_random_traffic(100);
    wait_all_results();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
